[sv/sei_pkg.sv]
// ----------------------------------------------------------------------------
// sei_pkg: shared types, widths and helpers for the segment/edge test
// Coordinate widths, pipeline payload structs, CSR and result codes, and
// the small geometry helpers used by more than one pipeline module.
// ----------------------------------------------------------------------------
package sei_pkg;

   // Widths
   localparam int COORD_BITS = 16;
   localparam int FIELD_W    = 16;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int CROSS_W    = PROD_W + 1;
   localparam int MAG_W      = PROD_W;
   localparam int NUM_W      = CROSS_W + DIFF_W + 1;
   localparam int QUO_W      = COORD_BITS;
   localparam int PX_W       = COORD_BITS + CROSS_W;
   localparam int TX_W       = CROSS_W + DIFF_W;
   localparam int EPS_LEN_W  = 16;
   localparam int EPS_AREA_W = 34;
   localparam int CSR_W      = 34;
   localparam int CSR_IDX_W  = 2;
   localparam int KIND_W     = 3;
   localparam int NEAR_W     = (DIFF_W + 1 > EPS_LEN_W) ? DIFF_W + 1 : EPS_LEN_W;
   localparam int AREA_W     = (MAG_W > EPS_AREA_W) ? MAG_W : EPS_AREA_W;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STRICT   = 2'd0,
      CSR_EPS_LEN  = 2'd1,
      CSR_EPS_AREA = 2'd2
   } csr_idx_type;

   // Result kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_MISS     = 3'd0,
      KIND_CROSS    = 3'd1,
      KIND_IDENT    = 3'd2,
      KIND_PARALLEL = 3'd3,
      KIND_TOUCH    = 3'd4
   } kind_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]     diff_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [CROSS_W-1:0]    cross_type;
   typedef logic        [MAG_W-1:0]      mag_type;
   typedef logic        [NUM_W-1:0]      num_mag_type;
   typedef logic        [QUO_W-1:0]      quo_type;

   typedef struct packed {
      logic                  strict;
      logic [EPS_LEN_W-1:0]  eps_len;
      logic [EPS_AREA_W-1:0] eps_area;
   } cfg_type;

   typedef struct packed {
      coord_type q1x;
      coord_type q1y;
      coord_type q2x;
      coord_type q2y;
      coord_type e1x;
      coord_type e1y;
      coord_type e2x;
      coord_type e2y;
   } seg_type;

   // Cross-product stage output
   typedef struct packed {
      seg_type   seg;
      logic      last;
      logic      ident;
      diff_type  s1x;
      diff_type  s1y;
      cross_type den;
      cross_type sn;
      cross_type tn;
   } cross_out_type;

   // Side data carried through the divider
   typedef struct packed {
      seg_type seg;
      logic    last;
      logic    ident;
      logic    par;
      logic    in_range;
      logic    neg_x;
      logic    neg_y;
   } ctx_type;

   typedef struct packed {
      ctx_type     ctx;
      num_mag_type num_x;
      num_mag_type num_y;
      mag_type     den_mag;
   } div_in_type;

   typedef struct packed {
      ctx_type ctx;
      quo_type quo_x;
      quo_type quo_y;
   } div_out_type;

   // Low COORD_BITS of a field, sign-extended
   function automatic coord_type to_coord(logic signed [FIELD_W-1:0] v);
      return COORD_BITS'(v);
   endfunction

   // |a - b| < eps on one axis
   function automatic logic near_1d(diff_type a, diff_type b, logic [EPS_LEN_W-1:0] eps);
      logic signed [DIFF_W:0] d;
      logic        [DIFF_W:0] m;
      d = (DIFF_W + 1)'(a) - (DIFF_W + 1)'(b);
      m = d[DIFF_W] ? unsigned'(-d) : unsigned'(d);
      return NEAR_W'(m) < NEAR_W'(eps);
   endfunction

   function automatic logic near_pt(diff_type ax, diff_type ay, diff_type bx, diff_type by,
                                    logic [EPS_LEN_W-1:0] eps);
      return near_1d(ax, bx, eps) && near_1d(ay, by, eps);
   endfunction

   function automatic mag_type abs_cross(cross_type x);
      cross_type n;
      n = x[CROSS_W-1] ? -x : x;
      return n[MAG_W-1:0];
   endfunction

   // num/den within [0,1], den nonzero
   function automatic logic unit_range(cross_type num, cross_type den);
      logic r;
      if (num == '0) begin
         r = 1'b1;
      end else if (num[CROSS_W-1] != den[CROSS_W-1]) begin
         r = 1'b0;
      end else begin
         r = abs_cross(num) <= abs_cross(den);
      end
      return r;
   endfunction

endpackage

[sv/sei_cross.sv]
// ----------------------------------------------------------------------------
// sei_cross: difference, identical-edge and cross-product stages
// Four register stages: input capture, differences and identical-edge check,
// six 17x17 products, then the denominator and both parameter numerators.
// ----------------------------------------------------------------------------
module sei_cross (
   input  logic                   clock,
   input  logic                   reset,
   input  sei_pkg::cfg_type       cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  sei_pkg::seg_type       in_seg,
   input  logic                   in_last,
   output logic                   out_valid,
   input  logic                   out_ready,
   output sei_pkg::cross_out_type out_data
);
   import sei_pkg::*;

   logic          a_v_ff, b_v_ff, c_v_ff, d_v_ff;
   logic          en_a, en_b, en_c, en_d;
   seg_type       a_seg_ff, b_seg_ff, c_seg_ff;
   logic          a_last_ff, b_last_ff, c_last_ff;
   logic          b_ident_ff, c_ident_ff;
   logic          ident_in;
   diff_type      s1x_in, s1y_in, s2x_in, s2y_in, ax_in, ay_in;
   diff_type      b_s1x_ff, b_s1y_ff, b_s2x_ff, b_s2y_ff, b_ax_ff, b_ay_ff;
   diff_type      c_s1x_ff, c_s1y_ff;
   prod_type      c_p0_ff, c_p1_ff, c_p2_ff, c_p3_ff, c_p4_ff, c_p5_ff;
   cross_out_type d_in, d_ff;

   // Stage enables: a stage moves when empty or when its successor moves
   assign en_d     = !d_v_ff || out_ready;
   assign en_c     = !c_v_ff || en_d;
   assign en_b     = !b_v_ff || en_c;
   assign en_a     = !a_v_ff || en_b;
   assign in_ready = en_a;

   // Differences and identical-edge check, either direction
   always_comb begin
      s1x_in   = DIFF_W'(a_seg_ff.q2x) - DIFF_W'(a_seg_ff.q1x);
      s1y_in   = DIFF_W'(a_seg_ff.q2y) - DIFF_W'(a_seg_ff.q1y);
      s2x_in   = DIFF_W'(a_seg_ff.e2x) - DIFF_W'(a_seg_ff.e1x);
      s2y_in   = DIFF_W'(a_seg_ff.e2y) - DIFF_W'(a_seg_ff.e1y);
      ax_in    = DIFF_W'(a_seg_ff.q1x) - DIFF_W'(a_seg_ff.e1x);
      ay_in    = DIFF_W'(a_seg_ff.q1y) - DIFF_W'(a_seg_ff.e1y);
      ident_in =
         (near_pt(DIFF_W'(a_seg_ff.q1x), DIFF_W'(a_seg_ff.q1y),
                  DIFF_W'(a_seg_ff.e1x), DIFF_W'(a_seg_ff.e1y), cfg.eps_len) &&
          near_pt(DIFF_W'(a_seg_ff.q2x), DIFF_W'(a_seg_ff.q2y),
                  DIFF_W'(a_seg_ff.e2x), DIFF_W'(a_seg_ff.e2y), cfg.eps_len)) ||
         (near_pt(DIFF_W'(a_seg_ff.q2x), DIFF_W'(a_seg_ff.q2y),
                  DIFF_W'(a_seg_ff.e1x), DIFF_W'(a_seg_ff.e1y), cfg.eps_len) &&
          near_pt(DIFF_W'(a_seg_ff.q1x), DIFF_W'(a_seg_ff.q1y),
                  DIFF_W'(a_seg_ff.e2x), DIFF_W'(a_seg_ff.e2y), cfg.eps_len));
   end

   // Denominator and numerators
   always_comb begin
      d_in       = '0;
      d_in.seg   = c_seg_ff;
      d_in.last  = c_last_ff;
      d_in.ident = c_ident_ff;
      d_in.s1x   = c_s1x_ff;
      d_in.s1y   = c_s1y_ff;
      d_in.den   = CROSS_W'(c_p0_ff) - CROSS_W'(c_p1_ff);
      d_in.sn    = CROSS_W'(c_p2_ff) - CROSS_W'(c_p3_ff);
      d_in.tn    = CROSS_W'(c_p4_ff) - CROSS_W'(c_p5_ff);
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
      end else begin
         if (en_a) a_v_ff <= in_valid;
         if (en_b) b_v_ff <= a_v_ff;
         if (en_c) c_v_ff <= b_v_ff;
         if (en_d) d_v_ff <= c_v_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (en_a) begin
         a_seg_ff  <= in_seg;
         a_last_ff <= in_last;
      end
      if (en_b) begin
         b_seg_ff   <= a_seg_ff;
         b_last_ff  <= a_last_ff;
         b_ident_ff <= ident_in;
         b_s1x_ff   <= s1x_in;
         b_s1y_ff   <= s1y_in;
         b_s2x_ff   <= s2x_in;
         b_s2y_ff   <= s2y_in;
         b_ax_ff    <= ax_in;
         b_ay_ff    <= ay_in;
      end
      if (en_c) begin
         c_seg_ff   <= b_seg_ff;
         c_last_ff  <= b_last_ff;
         c_ident_ff <= b_ident_ff;
         c_s1x_ff   <= b_s1x_ff;
         c_s1y_ff   <= b_s1y_ff;
         c_p0_ff    <= PROD_W'(b_s1x_ff) * PROD_W'(b_s2y_ff);
         c_p1_ff    <= PROD_W'(b_s2x_ff) * PROD_W'(b_s1y_ff);
         c_p2_ff    <= PROD_W'(b_s1x_ff) * PROD_W'(b_ay_ff);
         c_p3_ff    <= PROD_W'(b_s1y_ff) * PROD_W'(b_ax_ff);
         c_p4_ff    <= PROD_W'(b_s2x_ff) * PROD_W'(b_ay_ff);
         c_p5_ff    <= PROD_W'(b_s2y_ff) * PROD_W'(b_ax_ff);
      end
      if (en_d) begin
         d_ff <= d_in;
      end
   end

   assign out_valid = d_v_ff;
   assign out_data  = d_ff;

endmodule

[sv/sei_point.sv]
// ----------------------------------------------------------------------------
// sei_point: classification and crossing-point numerator stages
// Stage E checks the parallel threshold and the [0,1] parameter ranges and
// forms the four numerator products; stage F sums them into sign/magnitude.
// ----------------------------------------------------------------------------
module sei_point (
   input  logic                   clock,
   input  logic                   reset,
   input  sei_pkg::cfg_type       cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  sei_pkg::cross_out_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output sei_pkg::div_in_type    out_data
);
   import sei_pkg::*;

   logic                     e_v_ff, f_v_ff;
   logic                     en_e, en_f;
   seg_type                  e_seg_ff;
   logic                     e_last_ff, e_ident_ff, e_par_ff, e_range_ff, e_dneg_ff;
   mag_type                  e_dmag_ff;
   logic signed [PX_W-1:0]   e_px_ff, e_py_ff;
   logic signed [TX_W-1:0]   e_tx_ff, e_ty_ff;
   mag_type                  dmag_in;
   logic                     par_in, range_in;
   logic signed [NUM_W-1:0]  num_x, num_y;
   div_in_type               f_in, f_ff;

   assign en_f     = !f_v_ff || out_ready;
   assign en_e     = !e_v_ff || en_f;
   assign in_ready = en_e;

   // Parallel threshold and parameter range
   always_comb begin
      dmag_in  = abs_cross(in_data.den);
      par_in   = (in_data.den == '0) || (AREA_W'(dmag_in) < AREA_W'(cfg.eps_area));
      range_in = unit_range(in_data.sn, in_data.den) && unit_range(in_data.tn, in_data.den);
   end

   // Numerator sums: q1*den + tn*s1 per axis
   always_comb begin
      num_x            = NUM_W'(e_px_ff) + NUM_W'(e_tx_ff);
      num_y            = NUM_W'(e_py_ff) + NUM_W'(e_ty_ff);
      f_in             = '0;
      f_in.ctx.seg     = e_seg_ff;
      f_in.ctx.last    = e_last_ff;
      f_in.ctx.ident   = e_ident_ff;
      f_in.ctx.par     = e_par_ff;
      f_in.ctx.in_range = e_range_ff;
      f_in.ctx.neg_x   = num_x[NUM_W-1] != e_dneg_ff;
      f_in.ctx.neg_y   = num_y[NUM_W-1] != e_dneg_ff;
      f_in.num_x       = num_x[NUM_W-1] ? unsigned'(-num_x) : unsigned'(num_x);
      f_in.num_y       = num_y[NUM_W-1] ? unsigned'(-num_y) : unsigned'(num_y);
      f_in.den_mag     = e_dmag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
      end else begin
         if (en_e) e_v_ff <= in_valid;
         if (en_f) f_v_ff <= e_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_e) begin
         e_seg_ff   <= in_data.seg;
         e_last_ff  <= in_data.last;
         e_ident_ff <= in_data.ident;
         e_par_ff   <= par_in;
         e_range_ff <= range_in;
         e_dneg_ff  <= in_data.den[CROSS_W-1];
         e_dmag_ff  <= dmag_in;
         e_px_ff    <= PX_W'(in_data.seg.q1x) * PX_W'(in_data.den);
         e_py_ff    <= PX_W'(in_data.seg.q1y) * PX_W'(in_data.den);
         e_tx_ff    <= TX_W'(in_data.tn) * TX_W'(in_data.s1x);
         e_ty_ff    <= TX_W'(in_data.tn) * TX_W'(in_data.s1y);
      end
      if (en_f) begin
         f_ff <= f_in;
      end
   end

   assign out_valid = f_v_ff;
   assign out_data  = f_ff;

endmodule

[sv/sei_div.sv]
// ----------------------------------------------------------------------------
// sei_div: pipelined restoring divider for the crossing point
// One quotient bit per stage, x and y side by side, QUO_W stages. The
// quotient of a real crossing is bounded by the coordinate range, so the
// trial subtraction starts at the top quotient bit.
// ----------------------------------------------------------------------------
module sei_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  sei_pkg::div_in_type  in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output sei_pkg::div_out_type out_data
);
   import sei_pkg::*;

   logic        v_ff   [QUO_W];
   logic        en     [QUO_W];
   ctx_type     ctx_ff [QUO_W];
   num_mag_type rx_ff  [QUO_W];
   num_mag_type ry_ff  [QUO_W];
   quo_type     qx_ff  [QUO_W];
   quo_type     qy_ff  [QUO_W];
   mag_type     dm_ff  [QUO_W];

   ctx_type     ctx_src [QUO_W];
   num_mag_type rx_src  [QUO_W];
   num_mag_type ry_src  [QUO_W];
   quo_type     qx_src  [QUO_W];
   quo_type     qy_src  [QUO_W];
   mag_type     dm_src  [QUO_W];
   logic        v_src   [QUO_W];
   num_mag_type rx_in   [QUO_W];
   num_mag_type ry_in   [QUO_W];
   quo_type     qx_in   [QUO_W];
   quo_type     qy_in   [QUO_W];

   // Enable chain from the output back
   always_comb begin
      for (int k = QUO_W - 1; k >= 0; k--) begin
         if (k == QUO_W - 1) begin
            en[k] = !v_ff[k] || out_ready;
         end else begin
            en[k] = !v_ff[k] || en[k+1];
         end
      end
   end
   assign in_ready = en[0];

   // Per-stage trial subtract
   always_comb begin
      for (int k = 0; k < QUO_W; k++) begin
         logic [NUM_W:0] tx, ty;
         num_mag_type    sh;
         if (k == 0) begin
            v_src[k]   = in_valid;
            ctx_src[k] = in_data.ctx;
            rx_src[k]  = in_data.num_x;
            ry_src[k]  = in_data.num_y;
            qx_src[k]  = '0;
            qy_src[k]  = '0;
            dm_src[k]  = in_data.den_mag;
         end else begin
            v_src[k]   = v_ff[k-1];
            ctx_src[k] = ctx_ff[k-1];
            rx_src[k]  = rx_ff[k-1];
            ry_src[k]  = ry_ff[k-1];
            qx_src[k]  = qx_ff[k-1];
            qy_src[k]  = qy_ff[k-1];
            dm_src[k]  = dm_ff[k-1];
         end
         sh = NUM_W'(dm_src[k]) << (QUO_W - 1 - k);
         tx = {1'b0, rx_src[k]} - {1'b0, sh};
         ty = {1'b0, ry_src[k]} - {1'b0, sh};
         rx_in[k] = tx[NUM_W] ? rx_src[k] : tx[NUM_W-1:0];
         ry_in[k] = ty[NUM_W] ? ry_src[k] : ty[NUM_W-1:0];
         qx_in[k] = qx_src[k] | (QUO_W'(!tx[NUM_W]) << (QUO_W - 1 - k));
         qy_in[k] = qy_src[k] | (QUO_W'(!ty[NUM_W]) << (QUO_W - 1 - k));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QUO_W; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         for (int k = 0; k < QUO_W; k++) begin
            if (en[k]) v_ff[k] <= v_src[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QUO_W; k++) begin
         if (en[k]) begin
            ctx_ff[k] <= ctx_src[k];
            rx_ff[k]  <= rx_in[k];
            ry_ff[k]  <= ry_in[k];
            qx_ff[k]  <= qx_in[k];
            qy_ff[k]  <= qy_in[k];
            dm_ff[k]  <= dm_src[k];
         end
      end
   end

   assign out_valid      = v_ff[QUO_W-1];
   assign out_data.ctx   = ctx_ff[QUO_W-1];
   assign out_data.quo_x = qx_ff[QUO_W-1];
   assign out_data.quo_y = qy_ff[QUO_W-1];

endmodule

[sv/segment_edge_intersection_test.sv]
// ----------------------------------------------------------------------------
// segment_edge_intersection_test: streaming segment/edge intersection test
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  q1,q2,e1,e2 coords, last_edge
//   rsp_      out        rsp_valid/rsp_stall  hit, kind, last
//   csr_      in         csr_write            csr_index, csr_wdata
//
// One request per cycle sustained while rsp_stall is low; 4 cross-product
// stages, 2 numerator stages, 16 divider stages, 1 output register.
// Every stage holds a valid bit and fills when empty, so bubbles close up
// under rsp_stall. Synchronous reset empties the pipeline and loads the
// register defaults: strict 0, eps_len 1, eps_area 1.
// ----------------------------------------------------------------------------
module segment_edge_intersection_test (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [sei_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sei_pkg::CSR_W-1:0]           csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [sei_pkg::FIELD_W-1:0]  req_q1_x,
   input  logic signed [sei_pkg::FIELD_W-1:0]  req_q1_y,
   input  logic signed [sei_pkg::FIELD_W-1:0]  req_q2_x,
   input  logic signed [sei_pkg::FIELD_W-1:0]  req_q2_y,
   input  logic signed [sei_pkg::FIELD_W-1:0]  req_e1_x,
   input  logic signed [sei_pkg::FIELD_W-1:0]  req_e1_y,
   input  logic signed [sei_pkg::FIELD_W-1:0]  req_e2_x,
   input  logic signed [sei_pkg::FIELD_W-1:0]  req_e2_y,
   input  logic                                req_last_edge,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic [sei_pkg::KIND_W-1:0]          rsp_kind,
   output logic                                rsp_last
);
   import sei_pkg::*;

   cfg_type       cfg_ff;
   seg_type       req_seg;
   logic          cross_ready, cross_valid;
   cross_out_type cross_data;
   logic          point_ready, point_valid;
   div_in_type    point_data;
   logic          div_ready, div_valid;
   div_out_type   div_data;
   logic          en_o;
   logic          o_v_ff, o_hit_ff, o_last_ff;
   kind_type      o_kind_ff;
   logic          hit_in, touch;
   kind_type      kind_in;
   diff_type      ix, iy;
   ctx_type       cx;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.strict   <= 1'b0;
         cfg_ff.eps_len  <= EPS_LEN_W'(1);
         cfg_ff.eps_area <= EPS_AREA_W'(1);
      end else if (csr_write) begin
         case (csr_index)
            CSR_STRICT:   cfg_ff.strict   <= csr_wdata[0];
            CSR_EPS_LEN:  cfg_ff.eps_len  <= csr_wdata[EPS_LEN_W-1:0];
            CSR_EPS_AREA: cfg_ff.eps_area <= csr_wdata[EPS_AREA_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_seg.q1x = to_coord(req_q1_x);
   assign req_seg.q1y = to_coord(req_q1_y);
   assign req_seg.q2x = to_coord(req_q2_x);
   assign req_seg.q2y = to_coord(req_q2_y);
   assign req_seg.e1x = to_coord(req_e1_x);
   assign req_seg.e1y = to_coord(req_e1_y);
   assign req_seg.e2x = to_coord(req_e2_x);
   assign req_seg.e2y = to_coord(req_e2_y);

   assign req_stall = !cross_ready;

   sei_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (cross_ready),
      .in_seg    (req_seg),
      .in_last   (req_last_edge),
      .out_valid (cross_valid),
      .out_ready (point_ready),
      .out_data  (cross_data)
   );

   sei_point u_point (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (cross_valid),
      .in_ready  (point_ready),
      .in_data   (cross_data),
      .out_valid (point_valid),
      .out_ready (div_ready),
      .out_data  (point_data)
   );

   sei_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (point_valid),
      .in_ready  (div_ready),
      .in_data   (point_data),
      .out_valid (div_valid),
      .out_ready (en_o),
      .out_data  (div_data)
   );

   // Crossing point and endpoint touch
   always_comb begin
      cx    = div_data.ctx;
      ix    = cx.neg_x ? -signed'(DIFF_W'(div_data.quo_x)) : signed'(DIFF_W'(div_data.quo_x));
      iy    = cx.neg_y ? -signed'(DIFF_W'(div_data.quo_y)) : signed'(DIFF_W'(div_data.quo_y));
      touch = near_pt(ix, iy, DIFF_W'(cx.seg.q1x), DIFF_W'(cx.seg.q1y), cfg_ff.eps_len) ||
              near_pt(ix, iy, DIFF_W'(cx.seg.q2x), DIFF_W'(cx.seg.q2y), cfg_ff.eps_len) ||
              near_pt(ix, iy, DIFF_W'(cx.seg.e1x), DIFF_W'(cx.seg.e1y), cfg_ff.eps_len) ||
              near_pt(ix, iy, DIFF_W'(cx.seg.e2x), DIFF_W'(cx.seg.e2y), cfg_ff.eps_len);
   end

   // Final classification, in priority order
   always_comb begin
      if (cx.ident) begin
         hit_in  = !cfg_ff.strict;
         kind_in = KIND_IDENT;
      end else if (cx.par) begin
         hit_in  = 1'b0;
         kind_in = KIND_PARALLEL;
      end else if (cx.in_range) begin
         if (cfg_ff.strict && touch) begin
            hit_in  = 1'b0;
            kind_in = KIND_TOUCH;
         end else begin
            hit_in  = 1'b1;
            kind_in = KIND_CROSS;
         end
      end else begin
         hit_in  = 1'b0;
         kind_in = KIND_MISS;
      end
   end

   // Output register
   assign en_o = !o_v_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else if (en_o) begin
         o_v_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_o) begin
         o_hit_ff  <= hit_in;
         o_kind_ff <= kind_in;
         o_last_ff <= cx.last;
      end
   end

   assign rsp_valid = o_v_ff;
   assign rsp_hit   = o_hit_ff;
   assign rsp_kind  = o_kind_ff;
   assign rsp_last  = o_last_ff;

`ifndef SYNTHESIS
   // A hit is only ever a crossing or an identical edge
   a_hit_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> (rsp_kind == KIND_CROSS) || (rsp_kind == KIND_IDENT))
      else $error("hit reported with a non-hit kind");

   // With the output register empty the whole pipeline can move
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while output is empty");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule
